>>> hw/rtl/assert_macros.svh
// Assertion macros for the top level, the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BMD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BMD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bmd_pkg.sv
// Package with the shared constants and types of the button matrix debouncer.
`timescale 1ns / 1ps

package bmd_pkg;

  localparam int unsigned RowsDefault    = 4;
  localparam int unsigned ColumnsDefault = 4;
  localparam int unsigned CntW           = 8;
  localparam int unsigned SampleW        = 4;
  localparam int unsigned EvMax          = 4;
  localparam int unsigned SelW           = $clog2(EvMax);
  localparam int unsigned RowW           = 2;

  localparam logic [CntW-1:0] ReleaseCountReset = 8'd12;

  // Events of one row sample, handed from the update stage to the output buffer.
  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [SampleW-1:0] cur;
    logic [EvMax-1:0]   mask;
  } ev_load_t;

  // Status of the output buffer seen by the update stage.
  typedef struct packed {
    logic free;
  } buf_st_t;

endpackage

>>> hw/rtl/button_matrix_debouncer.sv
// Top level of the button matrix debouncer: row state memory, update stage and event output.
// An accepted row sample is registered into the update stage and its events then into the
// output buffer, from which m_axis takes them. One sample per cycle while samples have no
// events; a sample with events waits in the update stage until the buffer is free.
// Reset (rst_ni low, asynchronous) clears all row valid bits, so every row reads as zero,
// and loads release_count with 12.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_matrix_debouncer #(
  parameter int unsigned ROWS    = bmd_pkg::RowsDefault,
  parameter int unsigned COLUMNS = bmd_pkg::ColumnsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bmd_pkg::CntW-1:0] cfg_wdata_i,   // release_count
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [1:0] row_index, [5:2] column_bits
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,  // [1:0] button_x, [3:2] button_y
  output logic                     m_axis_tlast,  // last_event
  output logic                     m_axis_tuser   // pressed
);
  import bmd_pkg::*;

  localparam int unsigned RowAw    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned UsedCols = (COLUMNS < EvMax) ? COLUMNS : EvMax;
  localparam int unsigned CntTotW  = UsedCols * CntW;
  localparam int unsigned EntW     = 2 * SampleW + CntTotW;

  // Each memory word holds one row: the previous raw sample in the low bits, then the
  // debounced state, then one release counter per column.
  logic [EntW-1:0] mem_q [ROWS];
  logic [EntW-1:0] rd_data_q;
  logic            rd_vld_q;
  logic            row_vld_q [ROWS];

  logic [CntW-1:0] rel_cnt_q;

  logic [RowW-1:0]    in_row;
  logic [SampleW-1:0] in_cur;
  logic [4:0]         in_row_ext;
  logic               in_range;
  logic               s_acc;
  logic               rd_en;
  logic [RowAw-1:0]   rd_addr;

  logic               s1_valid_q;
  logic               s1_inr_q;
  logic [RowW-1:0]    s1_row_q;
  logic [SampleW-1:0] s1_cur_q;
  logic [4:0]         s1_row_ext;
  logic [RowAw-1:0]   wr_addr;

  logic               fwd_vld_q;
  logic [RowAw-1:0]   fwd_row_q;
  logic [EntW-1:0]    fwd_data_q;

  logic [EntW-1:0]    entry;
  logic [SampleW-1:0] prev;
  logic [SampleW-1:0] deb;
  logic [CntTotW-1:0] cnt_in;
  logic [SampleW-1:0] new_deb;
  logic [CntTotW-1:0] new_cnt;
  logic [EvMax-1:0]   ev_mask;
  logic [EntW-1:0]    wr_data;

  logic               s1_adv;
  logic               mem_we;
  logic               ev_load_en;
  ev_load_t           ev_load;
  buf_st_t            buf_st;
  logic               m_acc;

  // ---------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_cnt_q <= ReleaseCountReset;
    end else if (cfg_we_i) begin
      rel_cnt_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: an accepted sample launches the read of its row.
  // Rows at or above ROWS are carried along but never read, written or reported.
  // ---------------------------------------------------------------------------
  assign in_row     = s_axis_tdata[1:0];
  assign in_cur     = s_axis_tdata[5:2];
  assign in_row_ext = {3'b000, in_row};
  assign in_range   = (32'(in_row_ext) < ROWS);
  assign rd_addr    = in_row_ext[RowAw-1:0];
  assign s_acc      = s_axis_tvalid && s_axis_tready;
  assign rd_en      = s_acc && in_range;

  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= row_vld_q[rd_addr];
    end
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_inr_q <= in_range;
      s1_row_q <= in_row;
      s1_cur_q <= in_cur;
    end
  end

  // ---------------------------------------------------------------------------
  // Update stage. The memory read happens at the same edge as the write of the
  // sample before it, so the last written row is kept aside and replaces the read
  // data when the rows match. A row that was never written reads as zero.
  // ---------------------------------------------------------------------------
  assign s1_row_ext = {3'b000, s1_row_q};
  assign wr_addr    = s1_row_ext[RowAw-1:0];

  always_comb begin
    if (fwd_vld_q && (fwd_row_q == wr_addr)) begin
      entry = fwd_data_q;
    end else if (rd_vld_q) begin
      entry = rd_data_q;
    end else begin
      entry = '0;
    end
  end

  assign prev   = entry[SampleW-1:0];
  assign deb    = entry[2*SampleW-1:SampleW];
  assign cnt_in = entry[EntW-1:2*SampleW];

  // Every column is handled on its own. A fresh press is reported at once; a
  // fresh release loads the counter, which then counts down on stable scans and
  // reports the release when it reaches zero.
  always_comb begin
    logic            c;
    logic            dl;
    logic            ds;
    logic [CntW-1:0] cj;
    new_deb = deb;
    new_cnt = cnt_in;
    ev_mask = '0;
    for (int j = 0; j < UsedCols; j++) begin
      c  = s1_cur_q[j];
      dl = c ^ prev[j];
      ds = c ^ deb[j];
      cj = cnt_in[j*CntW +: CntW];
      if (dl && ds) begin
        if (c) begin
          new_deb[j] = 1'b1;
          ev_mask[j] = 1'b1;
        end else begin
          new_cnt[j*CntW +: CntW] = rel_cnt_q;
        end
      end else if (!dl && ds && (cj != '0)) begin
        new_cnt[j*CntW +: CntW] = cj - CntW'(1);
        if (cj == CntW'(1)) begin
          new_deb[j] = c;
          ev_mask[j] = 1'b1;
        end
      end
    end
    if (!s1_inr_q) begin
      ev_mask = '0;
    end
  end

  assign wr_data = {new_cnt, new_deb, s1_cur_q};

  // The stage moves on when it has nothing to report or the buffer can take it.
  assign s1_adv     = s1_valid_q && ((ev_mask == '0) || buf_st.free);
  assign mem_we     = s1_adv && s1_inr_q;
  assign ev_load_en = s1_adv && (ev_mask != '0);

  assign ev_load.row  = s1_row_q;
  assign ev_load.cur  = s1_cur_q;
  assign ev_load.mask = ev_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '{default: 1'b0};
      fwd_vld_q <= 1'b0;
    end else if (mem_we) begin
      row_vld_q[wr_addr] <= 1'b1;
      fwd_vld_q          <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fwd_row_q  <= wr_addr;
      fwd_data_q <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer: one event per cycle while m_axis_tready is high, lowest column first.
  // ---------------------------------------------------------------------------
  bmd_event_buf #(
    .COLUMNS(COLUMNS)
  ) u_event_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (ev_load),
    .load_en_i     (ev_load_en),
    .st_o          (buf_st),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  assign m_acc = m_axis_tvalid && m_axis_tready;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `BMD_ASSERT_NEXT(a_acc_fills_stage, s_acc, s1_valid_q, "item lost before the update stage")
  `BMD_ASSERT(a_no_overrun, ev_load_en |-> buf_st.free, "events loaded into a busy buffer")
  `BMD_ASSERT(a_we_needs_item, mem_we |-> (s1_valid_q && s1_inr_q), "row write without an item")
  `BMD_ASSERT_NEXT(a_more_events, m_acc && !m_axis_tlast, m_axis_tvalid, "event run cut short")

endmodule

>>> hw/rtl/bmd_event_buf.sv
// Output buffer that sends the events of one row sample, lowest column first.
`timescale 1ns / 1ps

module bmd_event_buf #(
  parameter int unsigned COLUMNS = bmd_pkg::ColumnsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmd_pkg::ev_load_t load_i,
  input  logic              load_en_i,
  output bmd_pkg::buf_st_t  st_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // [1:0] button_x, [3:2] button_y, [7:4] zero
  output logic              m_axis_tlast,  // last_event
  output logic              m_axis_tuser   // pressed
);
  import bmd_pkg::*;

  logic [EvMax-1:0]   mask_q, mask_d;
  logic [RowW-1:0]    row_q;
  logic [SampleW-1:0] cur_q;
  logic [SelW-1:0]    sel_idx;
  logic [EvMax-1:0]   sel_oh;
  logic [EvMax-1:0]   rest;
  logic [1:0]         x;
  logic               found;
  logic               take;

  always_comb begin
    found   = 1'b0;
    sel_idx = '0;
    for (int j = 0; j < EvMax; j++) begin
      if (!found && mask_q[j]) begin
        found   = 1'b1;
        sel_idx = SelW'(j);
      end
    end
  end

  assign sel_oh = {{(EvMax-1){1'b0}}, 1'b1} << sel_idx;
  assign rest   = mask_q & ~sel_oh;
  assign x      = 2'(int'(COLUMNS) - 1 - int'(sel_idx));

  assign m_axis_tvalid = (mask_q != '0);
  assign m_axis_tlast  = (rest == '0);
  assign m_axis_tuser  = cur_q[sel_idx];
  assign m_axis_tdata  = {4'b0000, row_q, x};
  assign take          = m_axis_tvalid && m_axis_tready;

  assign st_o.free = !m_axis_tvalid || (m_axis_tlast && m_axis_tready);

  always_comb begin
    mask_d = mask_q;
    if (load_en_i) begin
      mask_d = load_i.mask;
    end else if (take) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      row_q <= load_i.row;
      cur_q <= load_i.cur;
    end
  end

endmodule

>>> sim/button_matrix_debouncer_test.sv
// Self-checking testbench for the button matrix debouncer with a built-in event predictor.
`timescale 1ns / 1ps

module button_matrix_debouncer_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_SAMPLES = 58;
  localparam int DIRECTED_ROWS = 25;

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_e;

  typedef struct packed {
    logic [1:0] x;
    logic [1:0] y;
    logic       pressed;
    logic       last;
  } button_event_t;

  // One directed step: a row sample or a write of release_count. Where known is set,
  // press_mask lists the buttons that must report a press, and nothing else may come.
  typedef struct packed {
    step_kind_e                 kind;
    logic [1:0]                 row;
    logic [3:0]                 cols;
    logic [bmd_pkg::CntW-1:0]   value;
    logic                       known;
    logic [3:0]                 press_mask;
  } stim_row_t;

  localparam stim_row_t STIM_ROWS [DIRECTED_ROWS] = '{
    // Fresh after reset: presses are taken at once, all four columns in one sample.
    '{STEP_SAMPLE, 2'd0, 4'h0, 8'd0,   1'b1, 4'h0},
    '{STEP_SAMPLE, 2'd0, 4'hF, 8'd0,   1'b1, 4'hF},
    '{STEP_SAMPLE, 2'd3, 4'hF, 8'd0,   1'b1, 4'hF},
    '{STEP_SAMPLE, 2'd1, 4'h1, 8'd0,   1'b1, 4'h1},
    '{STEP_SAMPLE, 2'd2, 4'h8, 8'd0,   1'b1, 4'h8},
    '{STEP_SAMPLE, 2'd0, 4'hF, 8'd0,   1'b1, 4'h0},
    // Short release count: a full row lets go after two stable scans.
    '{STEP_WRITE,  2'd0, 4'h0, 8'd2,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd0, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd0, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd0, 4'h0, 8'd0,   1'b0, 4'h0},
    // A bounce back to pressed in the middle of a release.
    '{STEP_SAMPLE, 2'd1, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd1, 4'h1, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd1, 4'h1, 8'd0,   1'b0, 4'h0},
    // Zero release count: releases stick, and the stable mismatch with an idle counter.
    '{STEP_WRITE,  2'd0, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd3, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd3, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd3, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd3, 4'h5, 8'd0,   1'b0, 4'h0},
    // Release count of one: the scan after the edge already releases.
    '{STEP_WRITE,  2'd0, 4'h0, 8'd1,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd3, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd3, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd2, 4'h7, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd2, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_SAMPLE, 2'd2, 4'h0, 8'd0,   1'b0, 4'h0},
    '{STEP_WRITE,  2'd0, 4'h0, 8'd255, 1'b0, 4'h0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [bmd_pkg::CntW-1:0] cfg_wdata_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata = '0;   // [1:0] row_index, [5:2] column_bits
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [7:0]               m_axis_tdata;        // [1:0] button_x, [3:2] button_y
  logic                     m_axis_tlast;        // last_event
  logic                     m_axis_tuser;        // pressed

  // Predictor state: raw sample and debounced buttons per row, release timer per button.
  logic [3:0]               last_scan [4];
  logic [3:0]               held_state [4];
  logic [7:0]               release_timer [16];
  logic [bmd_pkg::CntW-1:0] release_setting;

  button_event_t pending_events [$];
  int            fail_count = 0;
  int            samples_sent = 0;
  int            events_seen = 0;
  int            settings_used = 0;
  int            cycle_count = 0;
  int            burst_left = 0;
  bit            hold_request = 1'b0;

  button_matrix_debouncer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one row sample to the predictor state and returns the number of events.
  // The events go to the pending queue only when publish is set.
  function automatic int debounce_row(input logic [1:0] row, input logic [3:0] cols,
                                      input bit publish);
    logic [3:0]    prev;
    logic [3:0]    deb;
    logic          moved;
    logic          differs;
    logic          fired;
    button_event_t ev;
    button_event_t found [$];
    prev = last_scan[row];
    deb  = held_state[row];
    for (int j = 0; j < 4; j++) begin
      moved   = cols[j] ^ prev[j];
      differs = cols[j] ^ deb[j];
      fired   = 1'b0;
      if (moved && differs) begin
        // A fresh press is taken at once, a fresh release arms the timer.
        if (cols[j]) begin
          deb[j] = 1'b1;
          fired  = 1'b1;
        end else begin
          release_timer[row * 4 + j] = release_setting;
        end
      end else if (!moved && differs && release_timer[row * 4 + j] != 8'd0) begin
        release_timer[row * 4 + j] = release_timer[row * 4 + j] - 8'd1;
        if (release_timer[row * 4 + j] == 8'd0) begin
          deb[j] = cols[j];
          fired  = 1'b1;
        end
      end
      if (fired) begin
        ev.x       = 2'(3 - j);
        ev.y       = row;
        ev.pressed = cols[j];
        ev.last    = 1'b0;
        found.push_back(ev);
      end
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    held_state[row] = deb;
    last_scan[row]  = cols;
    if (publish) begin
      foreach (found[k]) pending_events.push_back(found[k]);
    end
    return found.size();
  endfunction

  // Offers one row sample in bursts with random gaps, and predicts once it is taken.
  task automatic offer_sample(input logic [1:0] row, input logic [3:0] cols, input bit publish);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, cols, row};
    do @(posedge clk_i); while (!s_axis_tready);
    void'(debounce_row(row, cols, publish));
    samples_sent++;
  endtask

  // Waits until every predicted event is out and the pipeline has gone quiet.
  task automatic drain_events();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_release_count(input logic [bmd_pkg::CntW-1:0] value);
    drain_events();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    release_setting  = value;
    settings_used++;
  endtask

  // Receiver: changes its readiness pattern now and then, and holds off once on request.
  initial begin
    int mode;
    int mode_left;
    int held;
    bit hold_done;
    mode      = 0;
    mode_left = 0;
    held      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        m_axis_tready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 2) == 0);
          end
        endcase
      end
    end
  end

  // Event checker: every accepted event must match the oldest prediction.
  always @(posedge clk_i) begin
    button_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected event: x=%0d y=%0d pressed=%0d last=%0d",
               m_axis_tdata[1:0], m_axis_tdata[3:2], m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tdata[1:0] !== want.x) begin
          $error("button_x: expected %0d, got %0d", want.x, m_axis_tdata[1:0]);
          fail_count++;
        end
        if (m_axis_tdata[3:2] !== want.y) begin
          $error("button_y: expected %0d, got %0d", want.y, m_axis_tdata[3:2]);
          fail_count++;
        end
        if (m_axis_tuser !== want.pressed) begin
          $error("pressed: expected %0d, got %0d", want.pressed, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_event: expected %0d, got %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [bmd_pkg::CntW-1:0] phase_setting [6];
    logic [1:0]               row;
    logic [3:0]               cols;
    button_event_t            ev;
    int                       pick;
    int                       last_idx;

    release_setting = bmd_pkg::ReleaseCountReset;
    for (int r = 0; r < 4; r++) begin
      last_scan[r]  = 4'h0;
      held_state[r] = 4'h0;
    end
    for (int b = 0; b < 16; b++) release_timer[b] = 8'd0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed steps; rows with a known outcome carry their expected presses directly.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (STIM_ROWS[i].kind == STEP_WRITE) begin
        write_release_count(STIM_ROWS[i].value);
      end else begin
        offer_sample(STIM_ROWS[i].row, STIM_ROWS[i].cols, !STIM_ROWS[i].known);
        if (STIM_ROWS[i].known) begin
          last_idx = -1;
          for (int j = 0; j < 4; j++) begin
            if (STIM_ROWS[i].press_mask[j]) begin
              ev.x       = 2'(3 - j);
              ev.y       = STIM_ROWS[i].row;
              ev.pressed = 1'b1;
              ev.last    = 1'b0;
              pending_events.push_back(ev);
              last_idx = pending_events.size() - 1;
            end
          end
          if (last_idx >= 0) pending_events[last_idx].last = 1'b1;
        end
      end
    end

    // Random phases. The first runs with the largest count left by the directed part.
    phase_setting = '{8'd255, 8'd1, 8'd0, 8'd4, 8'(($urandom_range(5, 40))), 8'd2};
    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_release_count(phase_setting[p]);
      if (p == 1) hold_request = 1'b1;
      for (int s = 0; s < PHASE_SAMPLES; s++) begin
        row  = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        // Mostly stable scans so that timers run out; some single bounces and some noise.
        if (pick < 65) cols = last_scan[row];
        else if (pick < 90) cols = last_scan[row] ^ (4'h1 << $urandom_range(0, 3));
        else cols = 4'($urandom_range(0, 15));
        offer_sample(row, cols, 1'b1);
      end
    end

    drain_events();
    $display("Run covered %0d row samples and %0d button events under %0d release settings.",
             samples_sent, events_seen, settings_used + 1);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
